// ===== rtl/sid_pkg.sv =====
package sid_pkg;

  // Field widths fixed by the interface.
  localparam int SAMPLE_W = 32;
  localparam int THRESH_W = 31;
  localparam int RUN_W    = 32;
  localparam int CFG_W    = 32;

  // Defaults for the top-level parameters.
  localparam int INDEX_BITS_DEF  = 32;
  localparam int SAMPLE_BITS_DEF = 32;

  localparam logic [RUN_W-1:0]    MIN_RUN_RESET = RUN_W'(4802);
  localparam logic [THRESH_W-1:0] THRESH_RESET  = '0;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_QUIET_THRESHOLD = 1'b0,
    CFG_MIN_RUN_LENGTH  = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                       last_sample;
  } in_req_t;

  typedef struct packed {
    logic [RUN_W-1:0] run_start;
    logic [RUN_W-1:0] run_end;
  } out_req_t;

endpackage

// ===== rtl/silence_interval_detector.sv =====
// Channel  | Ports                         | Carries
// ---------+-------------------------------+------------------------------------------
// input    | in_valid, in_stall, in_data   | one audio sample and its last-sample mark
// result   | out_valid, out_stall, out_data| first and last index of a silence interval
// config   | cfg_we, cfg_index, cfg_data   | quiet threshold, minimum run length
//
// A sample's result, if it has one, goes from the input register to the result
// register, where it waits until it is taken. One sample is accepted per cycle
// unless a stalled result holds it back; the limit is the single run counter update.
// Reset (rst_n low, synchronous) clears the index, the open run and both
// valid flags, and loads the register defaults.
// A stalled result only holds back samples that would produce another result.
module silence_interval_detector import sid_pkg::*; #(
  parameter int INDEX_BITS  = INDEX_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,

  input  logic             in_valid,
  output logic             in_stall,
  input  in_req_t          in_data,

  output logic             out_valid,
  input  logic             out_stall,
  output out_req_t         out_data,

  input  logic             cfg_we,
  input  cfg_index_t       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  // Configuration registers.
  logic [THRESH_W-1:0] quiet_threshold_r;
  logic [RUN_W-1:0]    min_run_length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quiet_threshold_r <= THRESH_RESET;
      min_run_length_r  <= MIN_RUN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_QUIET_THRESHOLD: quiet_threshold_r <= cfg_data[THRESH_W-1:0];
        CFG_MIN_RUN_LENGTH:  min_run_length_r  <= cfg_data[RUN_W-1:0];
        default:             ;
      endcase
    end
  end

  // The magnitude is worked out ahead of the input register, so the stage
  // after it only has the threshold compare and the run counter update.
  logic [SAMPLE_BITS-2:0] in_magnitude;

  sid_magnitude #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_magnitude (
    .sample    (in_data.sample_value[SAMPLE_BITS-1:0]),
    .magnitude (in_magnitude)
  );

  logic                   s1_valid_r;
  logic                   s1_valid_nxt;
  logic [SAMPLE_BITS-2:0] s1_mag_r;
  logic                   s1_last_r;
  logic                   s1_adv;
  logic                   in_accept;

  // Run tracking state.
  logic [INDEX_BITS-1:0] sample_index_r, sample_index_nxt;
  logic                  run_active_r, run_active_nxt;
  logic [INDEX_BITS-1:0] run_begin_r, run_begin_nxt;
  logic [RUN_W-1:0]      run_count_r, run_count_nxt;

  logic                  quiet;
  logic [RUN_W-1:0]      count_step;
  logic                  res_valid;
  out_req_t              res;

  logic                  out_valid_r, out_valid_nxt;
  out_req_t              out_data_r;

  assign quiet = RUN_W'(s1_mag_r) <= RUN_W'(quiet_threshold_r);

  // Length of the run including this sample when it is quiet; saturates.
  always_comb begin
    if (!run_active_r) begin
      count_step = RUN_W'(1);
    end else if (run_count_r == '1) begin
      count_step = run_count_r;
    end else begin
      count_step = run_count_r + RUN_W'(1);
    end
  end

  // A run closes at a loud sample (ending one index earlier) or at a quiet
  // last sample (ending here). It is reported only if long enough.
  always_comb begin
    res.run_start = run_active_r ? 32'(run_begin_r) : 32'(sample_index_r);
    if (quiet) begin
      res_valid   = s1_last_r && (count_step >= min_run_length_r);
      res.run_end = 32'(sample_index_r);
    end else begin
      res_valid   = run_active_r && (run_count_r >= min_run_length_r);
      res.run_end = 32'(sample_index_r - INDEX_BITS'(1));
    end
  end

  always_comb begin
    run_active_nxt   = run_active_r;
    run_begin_nxt    = run_begin_r;
    run_count_nxt    = run_count_r;
    sample_index_nxt = sample_index_r;
    if (s1_adv) begin
      run_active_nxt   = quiet && !s1_last_r;
      run_count_nxt    = (quiet && !s1_last_r) ? count_step : '0;
      if (quiet && !run_active_r) begin
        run_begin_nxt = sample_index_r;
      end
      sample_index_nxt = s1_last_r ? '0 : sample_index_r + INDEX_BITS'(1);
    end
  end

  // The sample in the input register moves on unless it has a result and the
  // result register is still occupied by one the consumer has not taken.
  assign s1_adv    = s1_valid_r && (!res_valid || !out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  assign s1_valid_nxt = in_accept || (s1_valid_r && !s1_adv);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_adv && res_valid) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      sample_index_r <= '0;
      run_active_r   <= 1'b0;
      run_begin_r    <= '0;
      run_count_r    <= '0;
    end else begin
      s1_valid_r     <= s1_valid_nxt;
      out_valid_r    <= out_valid_nxt;
      sample_index_r <= sample_index_nxt;
      run_active_r   <= run_active_nxt;
      run_begin_r    <= run_begin_nxt;
      run_count_r    <= run_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_mag_r  <= in_magnitude;
      s1_last_r <= in_data.last_sample;
    end
    if (s1_adv && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // An open run always holds at least one sample, a closed one none.
  a_run_count_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (run_active_r == (run_count_r != '0)))
    else $error("run count disagrees with run_active");

  // The index restarts after the last sample of a recording.
  a_index_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_last_r) |=> (sample_index_r == '0 && !run_active_r))
    else $error("index or run not cleared after last sample");

  // A held sample is not dropped from the input register.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> s1_valid_r)
    else $error("held sample lost");

  // A new result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !(s1_adv && res_valid))
    else $error("result overwritten while stalled");

endmodule

// ===== rtl/sid_magnitude.sv =====
module sid_magnitude import sid_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic [SAMPLE_BITS-2:0] magnitude
);

  logic [SAMPLE_BITS-1:0] negated;

  assign negated = ~sample + SAMPLE_BITS'(1);

  // The most negative value has no positive twin and saturates to all ones.
  always_comb begin
    if (!sample[SAMPLE_BITS-1]) begin
      magnitude = sample[SAMPLE_BITS-2:0];
    end else if (sample[SAMPLE_BITS-2:0] == '0) begin
      magnitude = '1;
    end else begin
      magnitude = negated[SAMPLE_BITS-2:0];
    end
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the silence interval detector.
//
// A driver pulls sample requests from a queue that the stimulus process fills.
// A monitor watches both channels. Every accepted sample goes through a local
// model of the run tracker. That model keeps its own copy of the index, the
// open run and the two registers, and it queues the interval that the sample
// closes, if there is one. Every accepted result request is compared field by
// field with the oldest queued interval.
//
// The run moves through several register settings. The registers are only
// rewritten once the block has drained. The settings include both ends of the
// threshold range, a minimum of one, a minimum of zero and the largest
// minimum. Handshake pressure changes from phase to phase: no idling, a sender
// that is idle most of the time, a receiver that stalls most of the time, and
// both sides idling now and then.
module testbench;
  import sid_pkg::*;

  localparam int               CYCLE_LIMIT = 200000;
  localparam int               REPORT_MAX  = 10;
  localparam logic [30:0]      THR_MAX     = '1;
  localparam logic [RUN_W-1:0] RUN_MAX     = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic             in_valid = 1'b0;
  logic             in_stall;
  in_req_t          in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_req_t         out_data;
  logic             cfg_we = 1'b0;
  cfg_index_t       cfg_index = CFG_QUIET_THRESHOLD;
  logic [CFG_W-1:0] cfg_data = '0;

  silence_interval_detector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Samples that wait for the driver, and intervals that the block still owes us.
  in_req_t  pending_samples[$];
  out_req_t expected_intervals[$];

  // Percentages of cycles in which the sender idles or the receiver stalls.
  int send_idle_pct = 0;
  int stall_pct     = 0;

  // The local copy of the registers and of the run tracker. These start at
  // their reset values.
  logic [THRESH_W-1:0] quiet_limit = THRESH_RESET;
  logic [RUN_W-1:0]    min_run     = MIN_RUN_RESET;
  logic [31:0]         next_index  = '0;
  bit                  run_open    = 1'b0;
  logic [31:0]         run_first   = '0;
  logic [RUN_W-1:0]    run_len     = '0;

  int mismatches     = 0;
  int samples_seen   = 0;
  int intervals_seen = 0;
  int settings_used  = 1;
  int cycle_count    = 0;

  // The magnitude saturates, so the most negative sample counts as the
  // largest positive value.
  function automatic logic [31:0] sample_magnitude(logic signed [SAMPLE_W-1:0] s);
    logic [31:0] mag;
    if (!s[SAMPLE_W-1]) begin
      return s;
    end
    mag = -s;
    if (mag == 32'h8000_0000) begin
      mag = 32'h7FFF_FFFF;
    end
    return mag;
  endfunction

  // Advance the local tracker by one accepted sample. Queue the interval that
  // the sample closes, if the interval is long enough.
  task automatic track_sample(in_req_t req);
    logic [31:0] idx;
    bit          quiet;
    out_req_t    closed;
    idx   = next_index;
    quiet = sample_magnitude(req.sample_value) <= {1'b0, quiet_limit};
    if (quiet) begin
      if (!run_open) begin
        run_open  = 1'b1;
        run_first = idx;
        run_len   = 1;
      end else if (run_len != RUN_MAX) begin
        run_len = run_len + 1'b1;
      end
      // A quiet last sample belongs to the interval that it closes.
      if (req.last_sample) begin
        if (run_len >= min_run) begin
          closed.run_start = run_first;
          closed.run_end   = idx;
          expected_intervals = {expected_intervals, closed};
        end
        run_open = 1'b0;
        run_len  = '0;
      end
    end else begin
      // A loud sample ends the run at the previous index.
      if (run_open && run_len >= min_run) begin
        closed.run_start = run_first;
        closed.run_end   = idx - 1'b1;
        expected_intervals = {expected_intervals, closed};
      end
      run_open = 1'b0;
      run_len  = '0;
    end
    next_index = req.last_sample ? '0 : idx + 1'b1;
  endtask

  task automatic compare_interval(out_req_t got);
    out_req_t want;
    intervals_seen++;
    if (expected_intervals.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_MAX) begin
        $display("ERROR: unexpected interval start=%0d end=%0d", got.run_start, got.run_end);
      end
    end else begin
      want = expected_intervals.pop_front();
      if (got.run_start !== want.run_start || got.run_end !== want.run_end) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("ERROR: interval mismatch: start exp %0d got %0d, end exp %0d got %0d",
                   want.run_start, got.run_start, want.run_end, got.run_end);
        end
      end
    end
  endtask

  // The driver. A new request is only presented once the current one has
  // been taken, so a stalled payload holds still.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= pending_samples.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // The receiver stalls at random.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // The monitor. Prediction comes before checking in the same block, so an
  // interval is always queued before it can be compared.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        samples_seen++;
        track_sample(in_data);
      end
      if (out_valid && !out_stall) begin
        compare_interval(out_data);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d intervals outstanding.",
               cycle_count, expected_intervals.size());
      $display("silence_interval_detector test failed");
      $finish;
    end
  end

  // Wait until the sender has nothing left and no interval is outstanding.
  // The condition must then hold at consecutive checks, so that samples that
  // close no interval have also left the two-stage pipeline. The check is
  // made on the falling edge, clear of the updates at the rising edge.
  task automatic drain();
    int settled;
    settled = 0;
    while (settled < 6) begin
      @(negedge clk);
      if (pending_samples.size() == 0 && !in_valid && expected_intervals.size() == 0) begin
        settled++;
      end else begin
        settled = 0;
      end
    end
  endtask

  // Drain the block, write both registers and set the pressure for the next
  // phase. Draining is also where the sender waits for every result.
  task automatic reconfigure(logic [THRESH_W-1:0] thr, logic [RUN_W-1:0] min_len,
                             int send_pct, int rx_pct);
    drain();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_QUIET_THRESHOLD;
    cfg_data  <= {1'b0, thr};
    @(posedge clk);
    cfg_index <= CFG_MIN_RUN_LENGTH;
    cfg_data  <= min_len;
    @(posedge clk);
    cfg_we <= 1'b0;
    quiet_limit   = thr;
    min_run       = min_len;
    send_idle_pct = send_pct;
    stall_pct     = rx_pct;
    settings_used++;
  endtask

  task automatic push_sample(logic signed [SAMPLE_W-1:0] value, bit last);
    in_req_t req;
    req.sample_value = value;
    req.last_sample  = last;
    pending_samples = {pending_samples, req};
  endtask

  function automatic logic signed [SAMPLE_W-1:0] quiet_sample();
    logic [31:0] m;
    // At the top threshold the most negative value is quiet as well.
    if (quiet_limit == THR_MAX && $urandom_range(7) == 0) begin
      return 32'sh8000_0000;
    end
    case ($urandom_range(3))
      0:       m = '0;
      1:       m = {1'b0, quiet_limit};
      default: m = $urandom_range({1'b0, quiet_limit}, 0);
    endcase
    return ($urandom_range(1) != 0) ? -m : m;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] loud_sample();
    logic [31:0] m;
    logic [31:0] floor_mag;
    if (quiet_limit == THR_MAX) begin
      return quiet_sample();
    end
    floor_mag = {1'b0, quiet_limit} + 1'b1;
    case ($urandom_range(3))
      0:       m = floor_mag;
      1:       return 32'sh8000_0000;
      default: m = $urandom_range(32'h7FFF_FFFF, floor_mag);
    endcase
    return ($urandom_range(1) != 0) ? -m : m;
  endfunction

  // Quiet runs are made to fall just below, at and just above the minimum, capped at 24.
  function automatic int quiet_run_length();
    int cap;
    int len;
    cap = (min_run > 24) ? 24 : int'(min_run);
    case ($urandom_range(3))
      0:       len = cap - 1;
      1:       len = cap;
      2:       len = cap + 1;
      default: len = $urandom_range(2 * cap + 2, 1);
    endcase
    return (len < 1) ? 1 : len;
  endfunction

  // One recording ends with a last-sample mark. Most recordings alternate
  // quiet runs and short loud bursts. The rest are noise, with full-range
  // values and stray last marks.
  task automatic queue_recording(int max_len);
    int len;
    int k;
    int j;
    int burst;
    bit quiet_turn;
    len = $urandom_range(max_len, 1);
    if ($urandom_range(4) == 0) begin
      for (k = 0; k < len; k++) begin
        push_sample($urandom(), (k == len - 1) || ($urandom_range(9) == 0));
      end
    end else begin
      quiet_turn = $urandom_range(1);
      k = 0;
      while (k < len) begin
        burst = quiet_turn ? quiet_run_length() : $urandom_range(3, 1);
        for (j = 0; j < burst && k < len; j++) begin
          push_sample(quiet_turn ? quiet_sample() : loud_sample(), k == len - 1);
          k++;
        end
        quiet_turn = !quiet_turn;
      end
    end
  endtask

  task automatic random_phase(logic [THRESH_W-1:0] thr, logic [RUN_W-1:0] min_len,
                              int send_pct, int rx_pct, int n_samples);
    reconfigure(thr, min_len, send_pct, rx_pct);
    while (pending_samples.size() < n_samples) begin
      queue_recording(40);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: the threshold is zero and the minimum is far beyond a
    // short recording, so nothing may be reported.
    push_sample(32'sd0, 1'b0);
    push_sample(32'sd0, 1'b1);

    // Loud samples end runs, short runs are dropped, a quiet last sample closes
    // its run, and a loud last sample closes the run before it. The most
    // negative value is loud here.
    reconfigure(31'd100, 32'd2, 0, 0);
    push_sample(32'sd100, 1'b0);
    push_sample(-32'sd100, 1'b0);
    push_sample(32'sd101, 1'b0);
    push_sample(-32'sd101, 1'b0);
    push_sample(32'sd5, 1'b0);
    push_sample(32'sd200, 1'b0);
    push_sample(32'sd0, 1'b0);
    push_sample(32'sd0, 1'b0);
    push_sample(32'sd0, 1'b1);
    push_sample(32'sd0, 1'b0);
    push_sample(32'sh7FFF_FFFF, 1'b0);
    push_sample(32'sd0, 1'b0);
    push_sample(32'sd0, 1'b0);
    push_sample(32'sh8000_0000, 1'b1);
    push_sample(32'sd7, 1'b1);
    push_sample(-32'sd300, 1'b1);

    // Top threshold with a zero minimum. The saturated most negative value is
    // quiet, and a single quiet last sample is already an interval.
    reconfigure(THR_MAX, 32'd0, 0, 0);
    push_sample(32'sh8000_0000, 1'b0);
    push_sample(32'sh7FFF_FFFF, 1'b1);
    push_sample(-32'sd1, 1'b1);

    // Zero threshold with a minimum of one. Only exact zeros are quiet.
    reconfigure(31'd0, 32'd1, 0, 0);
    push_sample(32'sd0, 1'b0);
    push_sample(32'sd1, 1'b0);
    push_sample(-32'sd1, 1'b0);
    push_sample(32'sd0, 1'b1);

    // Random recordings under each kind of handshake pressure.
    random_phase(31'($urandom_range(1000, 10)), 32'd3, 0, 0, 80);
    random_phase(THR_MAX, 32'd1, 84, 0, 50);
    random_phase(31'd0, 32'd2, 0, 84, 60);
    random_phase(31'($urandom()), 32'($urandom_range(6, 1)), 33, 33, 80);
    random_phase(31'($urandom()), RUN_MAX, 0, 0, 30);
    random_phase(31'($urandom_range(5000, 1)), 32'd1, 33, 33, 60);

    drain();
    $display("Checked %0d samples and %0d silence intervals over %0d register settings.",
             samples_seen, intervals_seen, settings_used);
    $display("Handshake pressure ranged from none to 84 percent on either side.");
    if (mismatches == 0 && expected_intervals.size() == 0) begin
      $display("silence_interval_detector test passed");
    end else begin
      $display("%0d mismatches, %0d intervals never seen.",
               mismatches, expected_intervals.size());
      $display("silence_interval_detector test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sid_pkg.sv
rtl/sid_magnitude.sv
rtl/silence_interval_detector.sv
verif/testbench.sv
